>>> hw/rtl/dcqcn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCQCN rate controller package
// Widths, register indexes, reset values and shared helpers of the
// reaction-point rate controller.
// ----------------------------------------------------------------------------
package dcqcn_pkg;

  // Fixed-point format of rates and alpha: ONE stands for 100% or 1.0.
  localparam int RATE_FRAC_BITS = 16;
  localparam int RATE_W         = RATE_FRAC_BITS + 1;
  localparam logic [RATE_W-1:0] RATE_ONE = {1'b1, {RATE_FRAC_BITS{1'b0}}};

  // Field and state widths.
  localparam int MODE_W     = 2;
  localparam int BYTES_W    = 16;
  localparam int BYTE_CNT_W = 24;
  localparam int STAGE_W    = 16;
  localparam int TICK_W     = 16;
  localparam int STAGES_W   = 8;
  localparam int SHIFT_W    = 5;

  // Shared multiplier: covers both a rate and a stage difference.
  localparam int MUL_W = (RATE_W > STAGE_W + 1) ? RATE_W : STAGE_W + 1;
  localparam int SUM_W = 2 * MUL_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_THRESHOLD  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_STAGES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDITIVE_STEP   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYPER_STEP      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MINIMUM_RATE    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PERIOD    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_PERIOD     = 4'd7;

  // Register reset values.
  localparam logic [BYTE_CNT_W-1:0] BYTE_THRESHOLD_RST  = 24'd153600;
  localparam logic [STAGES_W-1:0]   RECOVERY_STAGES_RST = 8'd5;
  localparam logic [RATE_W-1:0]     ADDITIVE_STEP_RST   = 17'd328;
  localparam logic [RATE_W-1:0]     HYPER_STEP_RST      = 17'd655;
  localparam logic [RATE_W-1:0]     MINIMUM_RATE_RST    = 17'd1;
  localparam logic [SHIFT_W-1:0]    GAIN_SHIFT_RST      = 5'd8;
  localparam logic [TICK_W-1:0]     ALPHA_PERIOD_RST    = 16'd1;
  localparam logic [TICK_W-1:0]     RATE_PERIOD_RST     = 16'd20;

  // Event kinds; the fourth code is unused and leaves the state alone.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_PACKET = 2'd1,
    MODE_CNP    = 2'd2
  } mode_t;

  // Stage counters saturate at their all-ones value.
  function automatic logic [STAGE_W-1:0] sat_inc(input logic [STAGE_W-1:0] v);
    sat_inc = (v == {STAGE_W{1'b1}}) ? v : v + {{(STAGE_W-1){1'b0}}, 1'b1};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dcqcn_event_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCQCN event channel
// Valid/ready channel that carries one tick, sent-packet or CNP event a beat.
// ----------------------------------------------------------------------------
interface dcqcn_event_if;
  import dcqcn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [BYTES_W-1:0]   packet_bytes;

  modport source (output valid, output mode, output packet_bytes, input ready);
  modport sink   (input valid, input mode, input packet_bytes, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dcqcn_status_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCQCN status channel
// Valid/ready channel that carries the rate and alpha after each event.
// ----------------------------------------------------------------------------
interface dcqcn_status_if;
  import dcqcn_pkg::*;

  logic                valid;
  logic                ready;
  logic [RATE_W-1:0]   current_rate;
  logic [RATE_W-1:0]   congestion_alpha;
  logic                rate_changed;

  modport source (output valid, output current_rate, output congestion_alpha,
                  output rate_changed, input ready);
  modport sink   (input valid, input current_rate, input congestion_alpha,
                  input rate_changed, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dcqcn_rate_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCQCN rate controller
// Sender-side rate control: alpha estimate, target and current rate.
// ----------------------------------------------------------------------------
// Usage:
//   events : one beat per event (tick, sent packet with its byte count, or
//            congestion notification). Mode 3 leaves the state unchanged.
//   status : exactly one beat per event with the current rate and alpha
//            after that event, and a flag set when the rate was cut or
//            updated.
//   cfg    : plain register write port (cfg_wr_en, cfg_index, cfg_wdata);
//            write only while no event is in flight. Unknown indexes are
//            ignored.
// An accepted event beat reaches its status beat through one input
// register and one result register with a single pass of logic between
// them, where the shared 17x17 multiplier sets the critical path.
// Throughput is one event per cycle while the status receiver does not stall.
// Reset (synchronous, active high) restores the register defaults, full
// rate and alpha one, and empties both stages. When the status receiver
// stalls, one more event is taken into the input register; further events
// wait until the result register drains.
// ----------------------------------------------------------------------------
module dcqcn_rate_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [dcqcn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcqcn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  dcqcn_event_if.sink                       events,
  dcqcn_status_if.source                    status
);
  import dcqcn_pkg::*;

  // Configuration registers.
  logic [BYTE_CNT_W-1:0] byte_threshold;
  logic [STAGES_W-1:0]   recovery_stages;
  logic [RATE_W-1:0]     additive_step;
  logic [RATE_W-1:0]     hyper_step;
  logic [RATE_W-1:0]     minimum_rate;
  logic [SHIFT_W-1:0]    gain_shift;
  logic [TICK_W-1:0]     alpha_period;
  logic [TICK_W-1:0]     rate_period;

  // Controller state.
  logic [RATE_W-1:0]     alpha_value, alpha_value_next;
  logic [RATE_W-1:0]     target_rate, target_rate_next;
  logic [RATE_W-1:0]     rate_now, rate_now_next;
  logic [BYTE_CNT_W-1:0] byte_count, byte_count_next;
  logic [STAGE_W-1:0]    timer_stage_count, timer_stage_count_next;
  logic [STAGE_W-1:0]    byte_stage_count, byte_stage_count_next;
  logic [TICK_W-1:0]     alpha_tick_count, alpha_tick_count_next;
  logic [TICK_W-1:0]     rate_tick_count, rate_tick_count_next;
  logic                  alpha_timer_armed, alpha_timer_armed_next;
  logic                  changed;

  // Input and result registers.
  logic                  in_valid;
  logic [MODE_W-1:0]     mode_q;
  logic [BYTES_W-1:0]    bytes_q;
  logic                  out_valid;
  logic [RATE_W-1:0]     out_rate;
  logic [RATE_W-1:0]     out_alpha;
  logic                  out_changed;
  logic                  advance;

  // Datapath intermediates.
  logic                  is_tick, is_packet, is_cnp;
  logic [RATE_W-1:0]     alpha_decayed, alpha_raised;
  logic [TICK_W:0]       alpha_tick_inc, rate_tick_inc;
  logic                  alpha_fire, rate_fire;
  logic [BYTE_CNT_W:0]   byte_sum;
  logic                  byte_fire;
  logic                  do_update;
  logic [STAGE_W-1:0]    upd_r, upd_b, stage_min;
  logic [STAGE_W-1:0]    stages_ext;
  logic                  r_past, b_past, hyper;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [2*MUL_W-1:0]    mul_p;
  logic [2*MUL_W-1:0]    target_inc;
  logic [SUM_W-1:0]      target_sum;
  logic [RATE_W-1:0]     target_capped;
  logic [RATE_W+1:0]     rate_avg;
  logic [RATE_W-1:0]     cut_amount, rate_cut, floor_rate;

  // Handshake: the input register moves on whenever the result register
  // is empty or being drained.
  assign advance      = in_valid && (!out_valid || status.ready);
  assign events.ready = !in_valid || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_threshold  <= BYTE_THRESHOLD_RST;
      recovery_stages <= RECOVERY_STAGES_RST;
      additive_step   <= ADDITIVE_STEP_RST;
      hyper_step      <= HYPER_STEP_RST;
      minimum_rate    <= MINIMUM_RATE_RST;
      gain_shift      <= GAIN_SHIFT_RST;
      alpha_period    <= ALPHA_PERIOD_RST;
      rate_period     <= RATE_PERIOD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BYTE_THRESHOLD:  byte_threshold  <= cfg_wdata[BYTE_CNT_W-1:0];
        REG_RECOVERY_STAGES: recovery_stages <= cfg_wdata[STAGES_W-1:0];
        REG_ADDITIVE_STEP:   additive_step   <= cfg_wdata[RATE_W-1:0];
        REG_HYPER_STEP:      hyper_step      <= cfg_wdata[RATE_W-1:0];
        REG_MINIMUM_RATE:    minimum_rate    <= cfg_wdata[RATE_W-1:0];
        REG_GAIN_SHIFT:      gain_shift      <= cfg_wdata[SHIFT_W-1:0];
        REG_ALPHA_PERIOD:    alpha_period    <= cfg_wdata[TICK_W-1:0];
        REG_RATE_PERIOD:     rate_period     <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (events.ready) begin
      in_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      mode_q  <= events.mode;
      bytes_q <= events.packet_bytes;
    end
  end

  // Event decode.
  assign is_tick   = (mode_q == MODE_TICK);
  assign is_packet = (mode_q == MODE_PACKET);
  assign is_cnp    = (mode_q == MODE_CNP);

  // Alpha decay and raise share the truncating shift.
  assign alpha_decayed = alpha_value - (alpha_value >> gain_shift);
  assign alpha_raised  = alpha_decayed + (RATE_ONE >> gain_shift);

  // Timers count a tick and expire at their period; zero acts as one.
  assign alpha_tick_inc = {1'b0, alpha_tick_count} + {{TICK_W{1'b0}}, 1'b1};
  assign rate_tick_inc  = {1'b0, rate_tick_count} + {{TICK_W{1'b0}}, 1'b1};
  assign alpha_fire     = alpha_timer_armed && (alpha_tick_inc >= {1'b0, alpha_period});
  assign rate_fire      = rate_tick_inc >= {1'b0, rate_period};

  // Byte counter.
  assign byte_sum  = {1'b0, byte_count} + {{(BYTE_CNT_W+1-BYTES_W){1'b0}}, bytes_q};
  assign byte_fire = byte_sum >= {1'b0, byte_threshold};

  // Stage counts as seen by a rate update in this event.
  assign do_update = (is_tick && rate_fire) || (is_packet && byte_fire);
  assign upd_r     = is_tick ? sat_inc(timer_stage_count) : timer_stage_count;
  assign upd_b     = is_packet ? sat_inc(byte_stage_count) : byte_stage_count;
  assign stage_min = (upd_r < upd_b) ? upd_r : upd_b;
  assign stages_ext = {{(STAGE_W-STAGES_W){1'b0}}, recovery_stages};
  assign r_past    = upd_r > stages_ext;
  assign b_past    = upd_b > stages_ext;
  assign hyper     = r_past && b_past;

  // One multiplier: rate times alpha for a cut, stage span times hyper
  // step for an update.
  always_comb begin
    if (is_cnp) begin
      mul_a = {{(MUL_W-RATE_W){1'b0}}, rate_now};
      mul_b = {{(MUL_W-RATE_W){1'b0}}, alpha_value};
    end else begin
      mul_a = {{(MUL_W-STAGE_W){1'b0}}, stage_min}
            - {{(MUL_W-STAGE_W){1'b0}}, stages_ext}
            + {{(MUL_W-1){1'b0}}, 1'b1};
      mul_b = {{(MUL_W-RATE_W){1'b0}}, hyper_step};
    end
  end
  assign mul_p = mul_a * mul_b;

  // Target increase, cap at ONE, then average current toward target.
  always_comb begin
    if (hyper) begin
      target_inc = mul_p;
    end else if (r_past || b_past) begin
      target_inc = {{(2*MUL_W-RATE_W){1'b0}}, additive_step};
    end else begin
      target_inc = '0;
    end
  end
  assign target_sum    = {{(SUM_W-RATE_W){1'b0}}, target_rate} + {1'b0, target_inc};
  assign target_capped = (target_sum > {{(SUM_W-RATE_W){1'b0}}, RATE_ONE})
                       ? RATE_ONE : target_sum[RATE_W-1:0];
  assign rate_avg      = {2'b00, target_capped} + {2'b00, rate_now}
                       + {{(RATE_W+1){1'b0}}, 1'b1};

  // Multiplicative cut by alpha/2 with a floor.
  assign cut_amount = mul_p[RATE_W +: RATE_W];
  assign rate_cut   = rate_now - cut_amount;
  assign floor_rate = (minimum_rate > RATE_ONE) ? RATE_ONE : minimum_rate;

  // Next state of the controller.
  always_comb begin
    alpha_value_next       = alpha_value;
    target_rate_next       = target_rate;
    rate_now_next          = rate_now;
    byte_count_next        = byte_count;
    timer_stage_count_next = timer_stage_count;
    byte_stage_count_next  = byte_stage_count;
    alpha_tick_count_next  = alpha_tick_count;
    rate_tick_count_next   = rate_tick_count;
    alpha_timer_armed_next = alpha_timer_armed;
    changed                = 1'b0;

    if (is_tick) begin
      if (alpha_timer_armed) begin
        alpha_tick_count_next = alpha_fire ? '0 : alpha_tick_inc[TICK_W-1:0];
        if (alpha_fire) begin
          alpha_value_next = alpha_decayed;
        end
      end
      rate_tick_count_next = rate_fire ? '0 : rate_tick_inc[TICK_W-1:0];
      if (rate_fire) begin
        timer_stage_count_next = upd_r;
      end
    end else if (is_packet) begin
      byte_count_next = byte_fire ? '0 : byte_sum[BYTE_CNT_W-1:0];
      if (byte_fire) begin
        byte_stage_count_next = upd_b;
      end
    end else if (is_cnp) begin
      target_rate_next       = rate_now;
      rate_now_next          = (rate_cut < floor_rate) ? floor_rate : rate_cut;
      alpha_value_next       = alpha_raised;
      alpha_timer_armed_next = 1'b1;
      alpha_tick_count_next  = '0;
      rate_tick_count_next   = '0;
      byte_count_next        = '0;
      timer_stage_count_next = '0;
      byte_stage_count_next  = '0;
      changed                = 1'b1;
    end

    // Shared rate update for timer and byte stages.
    if (do_update) begin
      target_rate_next = target_capped;
      rate_now_next    = rate_avg[RATE_W:1];
      changed          = 1'b1;
    end
  end

  // State registers advance once per event.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_value       <= RATE_ONE;
      target_rate       <= RATE_ONE;
      rate_now          <= RATE_ONE;
      byte_count        <= '0;
      timer_stage_count <= '0;
      byte_stage_count  <= '0;
      alpha_tick_count  <= '0;
      rate_tick_count   <= '0;
      alpha_timer_armed <= 1'b0;
    end else if (advance) begin
      alpha_value       <= alpha_value_next;
      target_rate       <= target_rate_next;
      rate_now          <= rate_now_next;
      byte_count        <= byte_count_next;
      timer_stage_count <= timer_stage_count_next;
      byte_stage_count  <= byte_stage_count_next;
      alpha_tick_count  <= alpha_tick_count_next;
      rate_tick_count   <= rate_tick_count_next;
      alpha_timer_armed <= alpha_timer_armed_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rate    <= rate_now_next;
      out_alpha   <= alpha_value_next;
      out_changed <= changed;
    end
  end

  assign status.valid            = out_valid;
  assign status.current_rate     = out_rate;
  assign status.congestion_alpha = out_alpha;
  assign status.rate_changed     = out_changed;

endmodule
`default_nettype wire

>>> hw/rtl/dcqcn_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DCQCN rate controller checker
// Port-level assertions on the rate controller, attached by bind.
// ----------------------------------------------------------------------------
module dcqcn_checker (
  input  logic            clk,
  input  logic            rst,
  dcqcn_event_if.sink     events,
  dcqcn_status_if.source  status
);
  import dcqcn_pkg::*;

  // A stalled status beat keeps its payload.
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    status.valid && !status.ready |=> status.valid
      && $stable(status.current_rate) && $stable(status.congestion_alpha)
      && $stable(status.rate_changed))
    else $error("status beat changed while stalled");

  // The current rate never exceeds line rate.
  a_rate_bound: assert property (@(posedge clk) disable iff (rst)
    status.valid |-> status.current_rate <= RATE_ONE)
    else $error("current rate above line rate");

  // Alpha never exceeds one.
  a_alpha_bound: assert property (@(posedge clk) disable iff (rst)
    status.valid |-> status.congestion_alpha <= RATE_ONE)
    else $error("alpha above one");

  // An accepted event is followed by a presented status beat.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.ready |-> ##2 status.valid)
    else $error("no status beat after accepted event");

endmodule

bind dcqcn_rate_controller dcqcn_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .events (events),
  .status (status)
);
`default_nettype wire

>>> sim/dcqcn_rate_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCQCN rate controller scoreboard
// Watches the event, status and register ports, keeps its own copy of the
// rate, alpha, timer and counter state, and compares every status beat with
// the prediction made for the oldest outstanding event.
// ----------------------------------------------------------------------------
module dcqcn_rate_scoreboard
  import dcqcn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  dcqcn_event_if                evt,
  dcqcn_status_if               sts,
  output int                    failures,
  output int                    outstanding
);

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] alpha;
    logic              changed;
  } status_beat_t;

  // Register mirror.
  logic [BYTE_CNT_W-1:0] byte_limit;
  logic [STAGES_W-1:0]   recovery;
  logic [RATE_W-1:0]     add_unit;
  logic [RATE_W-1:0]     hyper_unit;
  logic [RATE_W-1:0]     rate_floor;
  logic [SHIFT_W-1:0]    gain;
  logic [TICK_W-1:0]     alpha_len;
  logic [TICK_W-1:0]     rate_len;

  // Controller state.
  logic [RATE_W-1:0]     est_alpha;
  logic [RATE_W-1:0]     tgt_rate;
  logic [RATE_W-1:0]     cur_rate;
  logic [BYTE_CNT_W-1:0] sent_bytes;
  logic [STAGE_W-1:0]    timer_stage;
  logic [STAGE_W-1:0]    byte_stage;
  logic [TICK_W-1:0]     alpha_ticks;
  logic [TICK_W-1:0]     rate_ticks;
  logic                  alpha_live;

  status_beat_t status_due_q[$];
  int           bad_beats = 0;

  // Target increase by stage, capped at full rate, then current moves
  // halfway toward target with the half rounded up.
  function automatic void raise_rate();
    logic [39:0]       sum;
    logic [STAGE_W-1:0] low_stage;
    logic [RATE_W:0]   avg;
    sum = 40'(tgt_rate);
    if (timer_stage > recovery && byte_stage > recovery) begin
      low_stage = (timer_stage < byte_stage) ? timer_stage : byte_stage;
      sum = sum + (40'(low_stage) - 40'(recovery) + 40'd1) * 40'(hyper_unit);
    end else if (timer_stage > recovery || byte_stage > recovery) begin
      sum = sum + 40'(add_unit);
    end
    if (sum > 40'(RATE_ONE)) sum = 40'(RATE_ONE);
    tgt_rate = sum[RATE_W-1:0];
    avg = ({1'b0, tgt_rate} + {1'b0, cur_rate} + 18'd1) >> 1;
    cur_rate = avg[RATE_W-1:0];
  endfunction

  // Apply one event to the state and return the status it should produce.
  function automatic status_beat_t predict_status(input logic [MODE_W-1:0] kind,
                                                  input logic [BYTES_W-1:0] nbytes);
    status_beat_t         beat;
    logic [TICK_W:0]      ticks_next;
    logic [BYTE_CNT_W:0]  bytes_next;
    logic [2*RATE_W-1:0]  drop;
    logic [RATE_W-1:0]    floor_now;
    beat.changed = 1'b0;
    case (kind)
      MODE_TICK: begin
        // The alpha timer only runs once a CNP has armed it.
        if (alpha_live) begin
          ticks_next = {1'b0, alpha_ticks} + 1'b1;
          if (ticks_next >= {1'b0, alpha_len}) begin
            alpha_ticks = '0;
            est_alpha = est_alpha - (est_alpha >> gain);
          end else begin
            alpha_ticks = ticks_next[TICK_W-1:0];
          end
        end
        ticks_next = {1'b0, rate_ticks} + 1'b1;
        if (ticks_next >= {1'b0, rate_len}) begin
          rate_ticks = '0;
          if (timer_stage != '1) timer_stage = timer_stage + 1'b1;
          raise_rate();
          beat.changed = 1'b1;
        end else begin
          rate_ticks = ticks_next[TICK_W-1:0];
        end
      end
      MODE_PACKET: begin
        bytes_next = {1'b0, sent_bytes} + (BYTE_CNT_W+1)'(nbytes);
        if (bytes_next >= {1'b0, byte_limit}) begin
          sent_bytes = '0;
          if (byte_stage != '1) byte_stage = byte_stage + 1'b1;
          raise_rate();
          beat.changed = 1'b1;
        end else begin
          sent_bytes = bytes_next[BYTE_CNT_W-1:0];
        end
      end
      MODE_CNP: begin
        // Cut by alpha/2 with a floor, then raise alpha and restart everything.
        floor_now = (rate_floor > RATE_ONE) ? RATE_ONE : rate_floor;
        tgt_rate = cur_rate;
        drop = ((2*RATE_W)'(cur_rate) * (2*RATE_W)'(est_alpha)) >> (RATE_FRAC_BITS + 1);
        cur_rate = cur_rate - drop[RATE_W-1:0];
        if (cur_rate < floor_now) cur_rate = floor_now;
        est_alpha = est_alpha - (est_alpha >> gain) + (RATE_ONE >> gain);
        alpha_live = 1'b1;
        alpha_ticks = '0;
        rate_ticks = '0;
        sent_bytes = '0;
        timer_stage = '0;
        byte_stage = '0;
        beat.changed = 1'b1;
      end
      default: begin
        // The spare code leaves everything alone.
      end
    endcase
    beat.rate = cur_rate;
    beat.alpha = est_alpha;
    return beat;
  endfunction

  // Mirror writes, check status beats against the queue, predict new events.
  always @(posedge clk) begin
    status_beat_t due;
    status_beat_t got;
    if (rst) begin
      byte_limit  = BYTE_THRESHOLD_RST;
      recovery    = RECOVERY_STAGES_RST;
      add_unit    = ADDITIVE_STEP_RST;
      hyper_unit  = HYPER_STEP_RST;
      rate_floor  = MINIMUM_RATE_RST;
      gain        = GAIN_SHIFT_RST;
      alpha_len   = ALPHA_PERIOD_RST;
      rate_len    = RATE_PERIOD_RST;
      est_alpha   = RATE_ONE;
      tgt_rate    = RATE_ONE;
      cur_rate    = RATE_ONE;
      sent_bytes  = '0;
      timer_stage = '0;
      byte_stage  = '0;
      alpha_ticks = '0;
      rate_ticks  = '0;
      alpha_live  = 1'b0;
      status_due_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BYTE_THRESHOLD:  byte_limit = cfg_wdata[BYTE_CNT_W-1:0];
          REG_RECOVERY_STAGES: recovery   = cfg_wdata[STAGES_W-1:0];
          REG_ADDITIVE_STEP:   add_unit   = cfg_wdata[RATE_W-1:0];
          REG_HYPER_STEP:      hyper_unit = cfg_wdata[RATE_W-1:0];
          REG_MINIMUM_RATE:    rate_floor = cfg_wdata[RATE_W-1:0];
          REG_GAIN_SHIFT:      gain       = cfg_wdata[SHIFT_W-1:0];
          REG_ALPHA_PERIOD:    alpha_len  = cfg_wdata[TICK_W-1:0];
          REG_RATE_PERIOD:     rate_len   = cfg_wdata[TICK_W-1:0];
          default: begin
          end
        endcase
      end

      if (sts.valid && sts.ready) begin
        got = '{sts.current_rate, sts.congestion_alpha, sts.rate_changed};
        if (status_due_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("%0t: status beat with no event outstanding: rate %0d alpha %0d changed %0d",
                     $realtime, got.rate, got.alpha, got.changed);
        end else begin
          due = status_due_q.pop_front();
          if (got.rate !== due.rate || got.alpha !== due.alpha ||
              got.changed !== due.changed) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("%0t: status mismatch: expected rate %0d alpha %0d changed %0d, got rate %0d alpha %0d changed %0d",
                       $realtime, due.rate, due.alpha, due.changed,
                       got.rate, got.alpha, got.changed);
          end
        end
      end

      if (evt.valid && evt.ready)
        status_due_q.push_back(predict_status(evt.mode, evt.packet_bytes));
    end
    outstanding <= status_due_q.size();
    failures <= bad_beats;
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCQCN rate controller testbench
// Drives ticks, sent packets and congestion notifications under a series of
// register settings, with random gaps on both channels, a long status stall
// and idle pauses, and lets the scoreboard check every status beat.
// ----------------------------------------------------------------------------
module testbench;
  import dcqcn_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = 4'd8;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dcqcn_event_if  evt ();
  dcqcn_status_if sts ();

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit hold_req = 1'b0;

  always #1 clk = ~clk;

  dcqcn_rate_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .events    (evt),
    .status    (sts)
  );

  dcqcn_rate_scoreboard scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .evt         (evt),
    .sts         (sts),
    .failures    (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (evt.valid && evt.ready) || (sts.valid && sts.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Status sink: a random stall before each beat while rx_gaps is set, and one long hold-off
  // on request so that the block fills up and stalls its event input.
  initial begin : status_sink
    int stall;
    sts.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        sts.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = rx_gaps ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        sts.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      sts.ready <= 1'b1;
      @(posedge clk);
      while (!sts.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one event beat after an optional gap and hold it until accepted.
  task automatic send_event(input logic [MODE_W-1:0] kind, input logic [BYTES_W-1:0] nbytes);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt.valid <= 1'b1;
    evt.mode <= kind;
    evt.packet_bytes <= nbytes;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every status beat has come back.
  task automatic wait_drained();
    evt.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; the caller lowers the enable after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'((junk << width) | value);
    @(negedge clk);
  endtask

  // Write every register, plus one write to an unmapped index.
  task automatic configure(input int unsigned thresh, input int unsigned stages,
                           input int unsigned add_step, input int unsigned hyp_step,
                           input int unsigned min_rate, input int unsigned shift,
                           input int unsigned a_period, input int unsigned r_period);
    write_reg(REG_BYTE_THRESHOLD, thresh, BYTE_CNT_W);
    write_reg(REG_RECOVERY_STAGES, stages, STAGES_W);
    write_reg(REG_ADDITIVE_STEP, add_step, RATE_W);
    write_reg(REG_HYPER_STEP, hyp_step, RATE_W);
    write_reg(REG_MINIMUM_RATE, min_rate, RATE_W);
    write_reg(REG_GAIN_SHIFT, shift, SHIFT_W);
    write_reg(REG_ALPHA_PERIOD, a_period, TICK_W);
    write_reg(REG_RATE_PERIOD, r_period, TICK_W);
    write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_FREE, (1 << CFG_IDX_W) - 1)),
              $urandom, CFG_DATA_W);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Random event: mostly ticks and packets, with CNPs now and then to arm
  // the alpha timer and restart recovery, and a few spare-code beats.
  task automatic send_random_event(input int cnp_pct);
    int roll;
    int pick;
    logic [BYTES_W-1:0] nbytes;
    roll = $urandom_range(0, 99);
    nbytes = BYTES_W'($urandom);
    if (roll < cnp_pct) begin
      send_event(MODE_CNP, nbytes);
    end else if (roll < cnp_pct + 4) begin
      send_event(MODE_SPARE, nbytes);
    end else if (roll < 56) begin
      send_event(MODE_TICK, nbytes);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) nbytes = '0;
      else if (pick == 1) nbytes = '1;
      else if (pick < 6) nbytes = BYTES_W'($urandom_range(0, 4095));
      send_event(MODE_PACKET, nbytes);
    end
  endtask

  // A run of random events with the idling pattern reshuffled now and then,
  // an idle pause halfway and optionally a long status stall.
  task automatic run_phase(input int count, input int cnp_pct, input bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_gaps = 1'($urandom_range(0, 1));
        rx_gaps = 1'($urandom_range(0, 1));
      end
      if (with_hold && i == count / 3) begin
        hold_req = 1'b1;
        tx_gaps = 1'b0;
      end
      if (i == count / 2) wait_drained();
      send_random_event(cnp_pct);
    end
    wait_drained();
  endtask

  initial begin
    evt.valid = 1'b0;
    evt.mode = MODE_TICK;
    evt.packet_bytes = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_BYTE_THRESHOLD;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on the reset settings: tick before any CNP, spare code,
    // packet extremes past the threshold, back-to-back cuts, alpha decay.
    send_event(MODE_TICK, '0);
    send_event(MODE_SPARE, '1);
    send_event(MODE_PACKET, '0);
    repeat (3) send_event(MODE_PACKET, '1);
    send_event(MODE_CNP, '1);
    send_event(MODE_CNP, '0);
    repeat (17) send_event(MODE_TICK, '1);
    wait_drained();

    // Settings sweep, extremes included: zero threshold, zero periods, a gain
    // shift of zero and one beyond the rate width, a floor above full rate, and
    // steps as large as full rate.
    configure(4000, 2, 328, 655, 1, 8, 1, 2);
    run_phase(170, 4, 1'b1);
    configure(0, 0, 65536, 65536, 'h1FFFF, 0, 0, 0);
    run_phase(120, 6, 1'b0);
    configure('hFFFFFF, 255, 0, 0, 0, 16, 65535, 65535);
    run_phase(50, 4, 1'b0);
    configure(1, 1, 1000, 50, 100, 1, 3, 1);
    run_phase(170, 4, 1'b1);
    configure(20000, 3, 2000, 300, 5000, 31, 2, 4);
    run_phase(170, 3, 1'b0);
    configure(100000, 5, 328, 655, 1, 4, 1, 5);
    run_phase(170, 2, 1'b0);

    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/dcqcn_pkg.sv
hw/rtl/dcqcn_event_if.sv
hw/rtl/dcqcn_status_if.sv
hw/rtl/dcqcn_rate_controller.sv
hw/rtl/dcqcn_checker.sv
sim/dcqcn_rate_scoreboard.sv
sim/testbench.sv
